// File: rtl/dfta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfta_pkg
// Shared constants, codes and types of the display frame text assembler.
// ----------------------------------------------------------------------------
package dfta_pkg;

   // sizes
   localparam int BUFFER_BYTES      = 32;
   localparam int LONG_TEXT_CHARS   = 64;
   localparam int SEGMENT_CHARS     = 12;
   localparam int SEG_FIRST         = 9;
   localparam int CHUNK_CHARS       = 4;
   localparam int LONG_APPEND_CHARS = 8;
   localparam int SEG_CHUNKS        = SEGMENT_CHARS / CHUNK_CHARS;

   localparam int BUF_AW    = $clog2(BUFFER_BYTES);
   localparam int WP_W      = $clog2(BUFFER_BYTES + 1);
   localparam int LT_AW     = $clog2(LONG_TEXT_CHARS);
   localparam int LT_LEN_W  = $clog2(LONG_TEXT_CHARS + 1);
   localparam int SEG_CW    = $clog2(SEGMENT_CHARS + 1);
   localparam int GA_W      = $clog2(SEG_FIRST + SEGMENT_CHARS + BUFFER_BYTES);
   localparam int CHUNK_W   = $clog2(SEG_CHUNKS);
   localparam int ISSUE_W   = $clog2(CHUNK_CHARS + 1);
   localparam int LAP_W     = $clog2(LONG_APPEND_CHARS);
   localparam int CHAR_W    = 7;

   // frame type and sub-type codes
   localparam logic [7:0] FT_ICONS = 8'h04;
   localparam logic [7:0] FT_START = 8'h10;
   localparam logic [7:0] FT_NOP   = 8'h70;
   localparam logic [7:0] CONT_LO  = 8'h21;
   localparam logic [7:0] CONT_HI  = 8'h7F;
   localparam logic [7:0] ST_ICONS = 8'h1C;
   localparam logic [7:0] ST_TEXT  = 8'h19;

   // register file
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_NEWS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_RDS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_TRAFFIC = 2'd2;
   localparam logic [7:0] NO_NEWS_RESET    = 8'h01;
   localparam logic [7:0] NO_RDS_RESET     = 8'h02;
   localparam logic [7:0] NO_TRAFFIC_RESET = 8'h04;

   typedef enum logic [2:0] {
      KIND_ICONS      = 3'd0,
      KIND_MODE       = 3'd1,
      KIND_BLINK_ADD  = 3'd2,
      KIND_BLINK_STOP = 3'd3,
      KIND_MENU_SHOW  = 3'd4,
      KIND_MENU_ITEM  = 3'd5,
      KIND_MENU_HIDE  = 3'd6,
      KIND_TEXT       = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      MODE_MANUAL  = 2'd0,
      MODE_PRESET  = 2'd1,
      MODE_UPDATE  = 2'd2,
      MODE_UNKNOWN = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] no_news;
      logic [7:0] no_rds;
      logic [7:0] no_traffic;
   } mask_type;

   // byte 0 is the frame type
   typedef logic [7:0][7:0] frame_type;

   typedef struct packed {
      kind_type                        kind;
      logic [CHUNK_CHARS-1:0][CHAR_W-1:0] chars;
      logic [2:0]                      chars_valid;
      logic                            last;
      logic                            news_on;
      logic                            traffic_on;
      logic                            rds_on;
      logic [1:0]                      radio_mode;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [BUF_AW-1:0] addr;
      logic [7:0]        data;
   } buf_wr_type;

   typedef struct packed {
      logic              en;
      logic [LT_AW-1:0]  addr;
      logic [CHAR_W-1:0] data;
   } lt_wr_type;

endpackage
`default_nettype wire

// File: rtl/display_frame_text_assembler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// display_frame_text_assembler_core
// Takes one 8-byte display frame per beat on req_ and sends icon, mode,
// blink, menu and text events on rsp_, up to four characters per text beat. The
// block works on one frame at a time: req_ready is high only while the
// sequencer is idle. An icon frame makes the icons beat and then the mode
// beat or mode check; a continuation frame appends its bytes (up to 7) one
// at a time, since the byte buffer RAM has a single write port. A completing
// frame then reads the 12 segment characters through the buffer RAM's read
// port, decides each event and sends the segment beats; a fullscreen segment
// appends up to 8 characters to the long text RAM, and the final one reads the
// long text RAM one character a cycle to fill beats of up to four characters.
// No clearing pass is needed after reset: unwritten buffer bytes read as zero
// through per-entry valid flags. The rsp_ side has an output register that
// the sequencer can load while it is empty or being drained; a beat stalled
// there holds the sequencer.
// ----------------------------------------------------------------------------
module display_frame_text_assembler_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration writes
   input  wire logic                           csr_wr_en,
   input  wire logic [dfta_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]                     csr_wdata,
   // frame beats
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_byte0,
   input  wire logic [7:0]                     req_byte1,
   input  wire logic [7:0]                     req_byte2,
   input  wire logic [7:0]                     req_byte3,
   input  wire logic [7:0]                     req_byte4,
   input  wire logic [7:0]                     req_byte5,
   input  wire logic [7:0]                     req_byte6,
   input  wire logic [7:0]                     req_byte7,
   // event beats
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [2:0]                          rsp_kind,
   output logic [6:0]                          rsp_char_a,
   output logic [6:0]                          rsp_char_b,
   output logic [6:0]                          rsp_char_c,
   output logic [6:0]                          rsp_char_d,
   output logic [2:0]                          rsp_chars_valid,
   output logic                                rsp_last,
   output logic                                rsp_news_on,
   output logic                                rsp_traffic_on,
   output logic                                rsp_rds_on,
   output logic [1:0]                          rsp_radio_mode
);
   import dfta_pkg::*;

   mask_type                masks_ff, masks_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   frame_type               frame;
   logic                    res_valid;
   logic                    res_ready;
   rsp_type                 res;
   buf_wr_type              buf_wr;
   logic [BUF_AW-1:0]       buf_raddr;
   logic [7:0]              buf_rdata;
   lt_wr_type               lt_wr;
   logic [LT_AW-1:0]        lt_raddr;
   logic [CHAR_W-1:0]       lt_rdata;

   assign frame = {req_byte7, req_byte6, req_byte5, req_byte4,
                   req_byte3, req_byte2, req_byte1, req_byte0};

   // indicator masks; the user must write them only while idle, the block does not enforce it
   always_comb begin
      masks_in = masks_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_NO_NEWS:    masks_in.no_news    = csr_wdata;
            CSR_NO_RDS:     masks_in.no_rds     = csr_wdata;
            CSR_NO_TRAFFIC: masks_in.no_traffic = csr_wdata;
            default: begin
               masks_in = masks_ff;
            end
         endcase
      end
   end

   // output register: the sequencer may load it whenever it is empty or
   // being drained in the same cycle
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         masks_ff.no_news    <= NO_NEWS_RESET;
         masks_ff.no_rds     <= NO_RDS_RESET;
         masks_ff.no_traffic <= NO_TRAFFIC_RESET;
         rsp_valid_ff        <= 1'b0;
      end else begin
         masks_ff     <= masks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_char_a      = rsp_ff.chars[0];
   assign rsp_char_b      = rsp_ff.chars[1];
   assign rsp_char_c      = rsp_ff.chars[2];
   assign rsp_char_d      = rsp_ff.chars[3];
   assign rsp_chars_valid = rsp_ff.chars_valid;
   assign rsp_last        = rsp_ff.last;
   assign rsp_news_on     = rsp_ff.news_on;
   assign rsp_traffic_on  = rsp_ff.traffic_on;
   assign rsp_rds_on      = rsp_ff.rds_on;
   assign rsp_radio_mode  = rsp_ff.radio_mode;

   // frame byte buffer
   dfta_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_buf_ram (
      .clock   (clock),
      .wr_en   (buf_wr.en),
      .wr_addr (buf_wr.addr),
      .wr_data (buf_wr.data),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   // fullscreen long text store, contents undefined until written
   dfta_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (LONG_TEXT_CHARS)
   ) u_lt_ram (
      .clock   (clock),
      .wr_en   (lt_wr.en),
      .wr_addr (lt_wr.addr),
      .wr_data (lt_wr.data),
      .rd_addr (lt_raddr),
      .rd_data (lt_rdata)
   );

   dfta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .masks     (masks_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .frame     (frame),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .buf_wr    (buf_wr),
      .buf_raddr (buf_raddr),
      .buf_rdata (buf_rdata),
      .lt_wr     (lt_wr),
      .lt_raddr  (lt_raddr),
      .lt_rdata  (lt_rdata)
   );

endmodule
`default_nettype wire

// File: rtl/dfta_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfta_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: rtl/dfta_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfta_ctrl
// Frame sequencer: decodes frames, appends to the byte buffer, gathers the
// twelve-character segment and walks the completion events.
// ----------------------------------------------------------------------------
module dfta_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dfta_pkg::mask_type         masks,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire dfta_pkg::frame_type        frame,
   output logic                            res_valid,
   input  wire logic                       res_ready,
   output dfta_pkg::rsp_type               res,
   output dfta_pkg::buf_wr_type            buf_wr,
   output logic [dfta_pkg::BUF_AW-1:0]     buf_raddr,
   input  wire logic [7:0]                 buf_rdata,
   output dfta_pkg::lt_wr_type             lt_wr,
   output logic [dfta_pkg::LT_AW-1:0]      lt_raddr,
   input  wire logic [dfta_pkg::CHAR_W-1:0] lt_rdata
);
   import dfta_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ICONS,
      S_MODE,
      S_APPEND,
      S_GATHER,
      S_BLINK,
      S_MENU,
      S_SEG,
      S_LAPPEND,
      S_LREAD,
      S_LOUT
   } state_type;

   localparam logic [2:0] CONT_LAST  = 3'd6;
   localparam logic [2:0] START_LAST = 3'd2;

   function automatic mode_type decode_mode(input logic [7:0] m);
      mode_type md;
      if (!m[5]) begin
         md = MODE_MANUAL;
      end else if (!m[1]) begin
         md = MODE_PRESET;
      end else begin
         md = MODE_UPDATE;
      end
      return md;
   endfunction

   // control registers
   state_type                state_ff, state_in;
   state_type                seg_ret_ff, seg_ret_in;
   kind_type                 seg_kind_ff, seg_kind_in;
   logic [2:0]               step_ff, step_in;
   logic                     start_mode_ff, start_mode_in;
   logic [WP_W-1:0]          wp_ff, wp_in;
   logic [7:0]               loc_ff, loc_in;
   mode_type                 cur_mode_ff, cur_mode_in;
   logic                     menu_vis_ff, menu_vis_in;
   logic [BUFFER_BYTES-1:0]  buf_vld_ff, buf_vld_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic [SEG_CW-1:0]        gcnt_ff, gcnt_in;
   logic [CHUNK_W-1:0]       chunk_ff, chunk_in;
   logic [LT_LEN_W-1:0]      lt_len_ff, lt_len_in;
   logic [LAP_W-1:0]         lap_ff, lap_in;
   logic [LT_LEN_W-1:0]      rptr_ff, rptr_in;
   logic [ISSUE_W-1:0]       issued_ff, issued_in;
   logic                     pend_ff, pend_in;
   logic [CHUNK_W-1:0]       slot_ff, slot_in;

   // payload registers
   logic [7:0]               data_ff [7];
   logic [7:0]               data_in [7];
   logic [CHAR_W-1:0]        seg_ff [SEGMENT_CHARS];
   logic [CHAR_W-1:0]        seg_in [SEGMENT_CHARS];
   logic [CHAR_W-1:0]        pack_ff [CHUNK_CHARS];
   logic [CHAR_W-1:0]        pack_in [CHUNK_CHARS];
   logic [7:0]               icon_ff, icon_in;
   logic [7:0]               modeb_ff, modeb_in;

   logic [GA_W-1:0]          ga_sum;
   logic [GA_W-1:0]          ga_addr;
   logic                     wp_full;
   logic [2:0]               mx;
   logic [2:0]               idx;
   logic                     sel;
   logic                     fs;
   mode_type                 new_mode;

   // gather address wraps around the buffer
   assign ga_sum    = GA_W'(SEG_FIRST) + GA_W'(gcnt_ff);
   assign ga_addr   = (ga_sum >= GA_W'(BUFFER_BYTES)) ? ga_sum - GA_W'(BUFFER_BYTES) : ga_sum;
   assign buf_raddr = ga_addr[BUF_AW-1:0];
   assign lt_raddr  = rptr_ff[LT_AW-1:0];

   assign wp_full  = (wp_ff >= WP_W'(BUFFER_BYTES));
   assign mx       = loc_ff[7:5];
   assign idx      = loc_ff[4:2];
   assign sel      = loc_ff[0];
   assign fs       = loc_ff[1];
   assign new_mode = decode_mode(modeb_ff);

   always_comb begin
      state_in      = state_ff;
      seg_ret_in    = seg_ret_ff;
      seg_kind_in   = seg_kind_ff;
      step_in       = step_ff;
      start_mode_in = start_mode_ff;
      wp_in         = wp_ff;
      loc_in        = loc_ff;
      cur_mode_in   = cur_mode_ff;
      menu_vis_in   = menu_vis_ff;
      buf_vld_in    = buf_vld_ff;
      rd_vld_in     = buf_vld_ff[buf_raddr];
      gcnt_in       = gcnt_ff;
      chunk_in      = chunk_ff;
      lt_len_in     = lt_len_ff;
      lap_in        = lap_ff;
      rptr_in       = rptr_ff;
      issued_in     = issued_ff;
      pend_in       = 1'b0;
      slot_in       = slot_ff;
      data_in       = data_ff;
      seg_in        = seg_ff;
      pack_in       = pack_ff;
      icon_in       = icon_ff;
      modeb_in      = modeb_ff;

      req_ready = (state_ff == S_IDLE);
      res_valid = 1'b0;
      res       = '0;
      res.last  = 1'b1;
      buf_wr    = '0;
      lt_wr     = '0;

      // long text read data lands in the cycle after the address
      if (pend_ff) begin
         pack_in[slot_ff] = lt_rdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (frame[0] == FT_ICONS) begin
                  icon_in  = frame[2];
                  modeb_in = frame[4];
                  state_in = S_ICONS;
               end else if (frame[0] == FT_START) begin
                  wp_in       = '0;
                  buf_wr.en   = 1'b1;
                  buf_wr.addr = '0;
                  buf_wr.data = '0;
                  if (frame[1] == ST_ICONS) begin
                     icon_in  = frame[3];
                     modeb_in = frame[5];
                     loc_in   = frame[7];
                     state_in = S_ICONS;
                  end else if (frame[1] == ST_TEXT) begin
                     loc_in        = frame[4];
                     data_in[0]    = frame[5];
                     data_in[1]    = frame[6];
                     data_in[2]    = frame[7];
                     step_in       = '0;
                     start_mode_in = 1'b1;
                     state_in      = S_APPEND;
                  end
               end else if ((frame[0] inside {[CONT_LO:CONT_HI]}) && (frame[0] != FT_NOP)) begin
                  for (int k = 0; k < 7; k++) begin
                     data_in[k] = frame[k+1];
                  end
                  step_in       = '0;
                  start_mode_in = 1'b0;
                  state_in      = S_APPEND;
               end
            end
         end

         S_ICONS: begin
            res_valid      = 1'b1;
            res.kind       = KIND_ICONS;
            res.news_on    = ((icon_ff & masks.no_news) == 8'h00);
            res.traffic_on = ((icon_ff & masks.no_traffic) == 8'h00);
            res.rds_on     = ((icon_ff & masks.no_rds) == 8'h00);
            if (res_ready) begin
               state_in = S_MODE;
            end
         end

         S_MODE: begin
            if (new_mode != cur_mode_ff) begin
               res_valid      = 1'b1;
               res.kind       = KIND_MODE;
               res.radio_mode = new_mode;
               if (res_ready) begin
                  cur_mode_in = new_mode;
                  state_in    = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         S_APPEND: begin
            for (int k = 0; k < 6; k++) begin
               data_in[k] = data_ff[k+1];
            end
            data_in[6]  = '0;
            buf_wr.addr = wp_ff[BUF_AW-1:0];
            buf_wr.data = data_ff[0];
            if (start_mode_ff) begin
               buf_wr.en = 1'b1;
               wp_in     = wp_ff + WP_W'(1);
               if (step_ff == START_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end else begin
               buf_wr.en = !wp_full;
               if (data_ff[0] == 8'h00) begin
                  gcnt_in  = '0;
                  state_in = (step_ff != CONT_LAST) ? S_GATHER : S_IDLE;
               end else begin
                  if (!wp_full) begin
                     wp_in = wp_ff + WP_W'(1);
                  end
                  if (step_ff == CONT_LAST) begin
                     state_in = S_IDLE;
                  end else begin
                     step_in = step_ff + 3'd1;
                  end
               end
            end
         end

         S_GATHER: begin
            if (gcnt_ff != '0) begin
               for (int k = 0; k < SEGMENT_CHARS - 1; k++) begin
                  seg_in[k] = seg_ff[k+1];
               end
               seg_in[SEGMENT_CHARS-1] = rd_vld_ff ? buf_rdata[CHAR_W-1:0] : '0;
            end
            if (gcnt_ff == SEG_CW'(SEGMENT_CHARS)) begin
               state_in = S_BLINK;
            end else begin
               gcnt_in = gcnt_ff + SEG_CW'(1);
            end
         end

         S_BLINK: begin
            if ((mx != 3'd0) && fs && !sel) begin
               seg_kind_in = KIND_BLINK_ADD;
               seg_ret_in  = S_MENU;
               chunk_in    = '0;
               state_in    = S_SEG;
            end else begin
               res_valid = 1'b1;
               res.kind  = KIND_BLINK_STOP;
               if (res_ready) begin
                  state_in = S_MENU;
               end
            end
         end

         S_MENU: begin
            if ((mx != 3'd0) && !fs) begin
               if (!menu_vis_ff) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_MENU_SHOW;
                  if (res_ready) begin
                     menu_vis_in = 1'b1;
                  end
               end else if (sel) begin
                  seg_kind_in = KIND_MENU_ITEM;
                  seg_ret_in  = S_IDLE;
                  chunk_in    = '0;
                  state_in    = S_SEG;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (menu_vis_ff) begin
               res_valid = 1'b1;
               res.kind  = KIND_MENU_HIDE;
               if (res_ready) begin
                  menu_vis_in = 1'b0;
               end
            end else if ((mx == 3'd0) && sel) begin
               seg_kind_in = KIND_TEXT;
               seg_ret_in  = S_IDLE;
               chunk_in    = '0;
               state_in    = S_SEG;
            end else if (fs && sel) begin
               if (idx == 3'd0) begin
                  lt_len_in = '0;
               end
               lap_in   = '0;
               state_in = S_LAPPEND;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_SEG: begin
            res_valid       = 1'b1;
            res.kind        = seg_kind_ff;
            res.chars_valid = 3'(CHUNK_CHARS);
            res.last        = (chunk_ff == CHUNK_W'(SEG_CHUNKS - 1));
            for (int k = 0; k < CHUNK_CHARS; k++) begin
               res.chars[k] = seg_ff[k];
            end
            if (res_ready) begin
               // rotate so the segment is whole again after the last chunk
               for (int k = 0; k < SEGMENT_CHARS; k++) begin
                  seg_in[k] = seg_ff[(k + CHUNK_CHARS < SEGMENT_CHARS) ?
                                     k + CHUNK_CHARS : k + CHUNK_CHARS - SEGMENT_CHARS];
               end
               if (res.last) begin
                  chunk_in = '0;
                  state_in = seg_ret_ff;
               end else begin
                  chunk_in = chunk_ff + CHUNK_W'(1);
               end
            end
         end

         S_LAPPEND: begin
            lt_wr.en   = (lt_len_ff < LT_LEN_W'(LONG_TEXT_CHARS));
            lt_wr.addr = lt_len_ff[LT_AW-1:0];
            lt_wr.data = seg_ff[0];
            if (lt_wr.en) begin
               lt_len_in = lt_len_ff + LT_LEN_W'(1);
            end
            for (int k = 0; k < SEGMENT_CHARS - 1; k++) begin
               seg_in[k] = seg_ff[k+1];
            end
            seg_in[SEGMENT_CHARS-1] = seg_ff[0];
            if (lap_ff == LAP_W'(LONG_APPEND_CHARS - 1)) begin
               if (idx == mx) begin
                  rptr_in   = '0;
                  issued_in = '0;
                  for (int k = 0; k < CHUNK_CHARS; k++) begin
                     pack_in[k] = '0;
                  end
                  state_in = S_LREAD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               lap_in = lap_ff + LAP_W'(1);
            end
         end

         S_LREAD: begin
            if ((issued_ff == ISSUE_W'(CHUNK_CHARS)) || (rptr_ff == lt_len_ff)) begin
               state_in = S_LOUT;
            end else begin
               pend_in   = 1'b1;
               slot_in   = issued_ff[CHUNK_W-1:0];
               rptr_in   = rptr_ff + LT_LEN_W'(1);
               issued_in = issued_ff + ISSUE_W'(1);
            end
         end

         S_LOUT: begin
            res_valid       = 1'b1;
            res.kind        = KIND_TEXT;
            res.chars_valid = 3'(issued_ff);
            res.last        = (rptr_ff == lt_len_ff);
            for (int k = 0; k < CHUNK_CHARS; k++) begin
               res.chars[k] = pack_ff[k];
            end
            if (res_ready) begin
               for (int k = 0; k < CHUNK_CHARS; k++) begin
                  pack_in[k] = '0;
               end
               issued_in = '0;
               state_in  = res.last ? S_IDLE : S_LREAD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (buf_wr.en) begin
         buf_vld_in[buf_wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         seg_ret_ff    <= S_IDLE;
         seg_kind_ff   <= KIND_TEXT;
         step_ff       <= '0;
         start_mode_ff <= 1'b0;
         wp_ff         <= '0;
         loc_ff        <= '0;
         cur_mode_ff   <= MODE_UNKNOWN;
         menu_vis_ff   <= 1'b0;
         buf_vld_ff    <= '0;
         rd_vld_ff     <= 1'b0;
         gcnt_ff       <= '0;
         chunk_ff      <= '0;
         lt_len_ff     <= '0;
         lap_ff        <= '0;
         rptr_ff       <= '0;
         issued_ff     <= '0;
         pend_ff       <= 1'b0;
         slot_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         seg_ret_ff    <= seg_ret_in;
         seg_kind_ff   <= seg_kind_in;
         step_ff       <= step_in;
         start_mode_ff <= start_mode_in;
         wp_ff         <= wp_in;
         loc_ff        <= loc_in;
         cur_mode_ff   <= cur_mode_in;
         menu_vis_ff   <= menu_vis_in;
         buf_vld_ff    <= buf_vld_in;
         rd_vld_ff     <= rd_vld_in;
         gcnt_ff       <= gcnt_in;
         chunk_ff      <= chunk_in;
         lt_len_ff     <= lt_len_in;
         lap_ff        <= lap_in;
         rptr_ff       <= rptr_in;
         issued_ff     <= issued_in;
         pend_ff       <= pend_in;
         slot_ff       <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      seg_ff   <= seg_in;
      pack_ff  <= pack_in;
      icon_ff  <= icon_in;
      modeb_ff <= modeb_in;
   end

endmodule
`default_nettype wire

// File: rtl/dfta_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfta_checker
// Port-level checks of the event channel, bound to the top level.
// ----------------------------------------------------------------------------
module dfta_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [2:0]                     rsp_kind,
   input wire logic [6:0]                     rsp_char_a,
   input wire logic [6:0]                     rsp_char_b,
   input wire logic [6:0]                     rsp_char_c,
   input wire logic [6:0]                     rsp_char_d,
   input wire logic [2:0]                     rsp_chars_valid,
   input wire logic                           rsp_last,
   input wire logic                           rsp_news_on,
   input wire logic                           rsp_traffic_on,
   input wire logic                           rsp_rds_on,
   input wire logic [1:0]                     rsp_radio_mode
);
   import dfta_pkg::*;

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_char_a) && $stable(rsp_chars_valid) && $stable(rsp_last))
      else $error("event beat changed while stalled");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("event beat valid after reset");

   // plain events carry no text and close their run
   a_plain_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ICONS || rsp_kind == KIND_MODE ||
      rsp_kind == KIND_BLINK_STOP || rsp_kind == KIND_MENU_SHOW ||
      rsp_kind == KIND_MENU_HIDE) |-> rsp_chars_valid == 3'd0 && rsp_last)
      else $error("plain event with text fields");

   // character slots past the count are zero
   a_slots_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chars_valid <= 3'd4 &&
      (rsp_chars_valid > 3'd0 || rsp_char_a == 7'd0) &&
      (rsp_chars_valid > 3'd1 || rsp_char_b == 7'd0) &&
      (rsp_chars_valid > 3'd2 || rsp_char_c == 7'd0) &&
      (rsp_chars_valid > 3'd3 || rsp_char_d == 7'd0))
      else $error("unused character slot not zero");

   // indicator and mode fields only on their own events
   a_field_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_ICONS ||
      (!rsp_news_on && !rsp_traffic_on && !rsp_rds_on)) &&
      (rsp_kind == KIND_MODE || rsp_radio_mode == 2'd0))
      else $error("event field set on wrong kind");

endmodule

bind display_frame_text_assembler_core dfta_checker u_dfta_checker (.*);
`default_nettype wire

// File: verif/display_frame_text_assembler_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// display_frame_text_assembler_core_test
// Drives display frames into the assembler with random gaps on the request
// side and random stalls on the event side. An in-bench predictor keeps its
// own copy of the text buffer, location, menu, mode and long text state and
// queues the event beats each accepted frame should cause. Every event beat
// is checked field by field against the oldest queued beat.
// ----------------------------------------------------------------------------
module display_frame_text_assembler_core_test;
   import dfta_pkg::*;

   localparam int SETTLE_CYCLES = 160;        // idle wait after the beat queue drains
   localparam int RANDOM_FRAMES = 90;
   localparam int REPORT_LIMIT  = 10;
   localparam int TIMEOUT_NS    = 10_000_000;

   // one event beat as seen on the rsp_ side, chars[0] is char_a
   typedef struct packed {
      kind_type        kind;
      logic [3:0][6:0] chars;
      logic [2:0]      chars_valid;
      logic            last;
      logic            news_on;
      logic            traffic_on;
      logic            rds_on;
      logic [1:0]      radio_mode;
   } event_beat_type;

   typedef logic [6:0] char_row_type [LONG_TEXT_CHARS];

   // dut connections, all inputs known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_byte0 = '0, req_byte1 = '0, req_byte2 = '0, req_byte3 = '0;
   logic [7:0]           req_byte4 = '0, req_byte5 = '0, req_byte6 = '0, req_byte7 = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [2:0]           rsp_kind;
   logic [6:0]           rsp_char_a, rsp_char_b, rsp_char_c, rsp_char_d;
   logic [2:0]           rsp_chars_valid;
   logic                 rsp_last, rsp_news_on, rsp_traffic_on, rsp_rds_on;
   logic [1:0]           rsp_radio_mode;

   // predictor state
   logic [7:0]     text_bytes [BUFFER_BYTES];
   int unsigned    fill_pos;
   logic [7:0]     location;
   logic           menu_shown;
   mode_type       shown_mode;
   char_row_type   long_text;
   int unsigned    long_len;
   mask_type       masks;
   event_beat_type beats_due [$];

   // bookkeeping
   int unsigned frames_sent  = 0;
   int unsigned noise_frames = 0;
   int unsigned mismatches   = 0;
   int unsigned rsp_hold     = 0;
   bit          steady       = 1'b0;   // no new gaps or stalls start while set

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   display_frame_text_assembler_core u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte0       (req_byte0),
      .req_byte1       (req_byte1),
      .req_byte2       (req_byte2),
      .req_byte3       (req_byte3),
      .req_byte4       (req_byte4),
      .req_byte5       (req_byte5),
      .req_byte6       (req_byte6),
      .req_byte7       (req_byte7),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_char_a      (rsp_char_a),
      .rsp_char_b      (rsp_char_b),
      .rsp_char_c      (rsp_char_c),
      .rsp_char_d      (rsp_char_d),
      .rsp_chars_valid (rsp_chars_valid),
      .rsp_last        (rsp_last),
      .rsp_news_on     (rsp_news_on),
      .rsp_traffic_on  (rsp_traffic_on),
      .rsp_rds_on      (rsp_rds_on),
      .rsp_radio_mode  (rsp_radio_mode)
   );

   // ------------------------------------------------------------------------
   // random helpers
   // ------------------------------------------------------------------------

   // mostly zero, then short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // nonzero text byte, arrows are picked often
   function automatic logic [7:0] text_char();
      if ($urandom_range(0, 9) < 2) return 8'($urandom_range(7, 10));
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] cont_type();
      logic [7:0] v;
      do v = 8'($urandom_range(CONT_LO, CONT_HI)); while (v == FT_NOP);
      return v;
   endfunction

   function automatic logic [7:0] rand_location();
      case ($urandom_range(0, 4))
         0: return {3'($urandom_range(1, 7)), 3'($urandom), 2'b10};          // blink add
         1: return {3'($urandom_range(1, 7)), 3'($urandom), 1'b0, 1'($urandom)}; // menu
         2: return {3'b000, 3'($urandom), 1'($urandom), 1'b1};              // raw text
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic frame_type frame_of(input logic [7:0] b0, b1, b2, b3,
                                          input logic [7:0] b4, b5, b6, b7);
      return {b7, b6, b5, b4, b3, b2, b1, b0};
   endfunction

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   function automatic void reset_model();
      text_bytes     = '{default: '0};
      long_text      = '{default: '0};
      fill_pos       = 0;
      location       = '0;
      menu_shown     = 1'b0;
      shown_mode     = MODE_UNKNOWN;
      long_len       = 0;
      masks.no_news    = NO_NEWS_RESET;
      masks.no_rds     = NO_RDS_RESET;
      masks.no_traffic = NO_TRAFFIC_RESET;
   endfunction

   // non-text beats carry no characters and always close their run
   function automatic event_beat_type plain_beat(kind_type kd);
      event_beat_type e;
      e      = '0;
      e.kind = kd;
      e.last = 1'b1;
      return e;
   endfunction

   // split a text into beats of up to four characters
   function automatic void queue_text(kind_type kd, char_row_type row, int unsigned len);
      event_beat_type e;
      int unsigned pos, n;
      pos = 0;
      if (len == 0) beats_due.push_back(plain_beat(kd));
      while (pos < len) begin
         e = plain_beat(kd);
         n = (len - pos > 4) ? 4 : len - pos;
         for (int i = 0; i < n; i++) e.chars[i] = row[pos + i];
         e.chars_valid = n[2:0];
         pos += n;
         e.last = (pos >= len);
         beats_due.push_back(e);
      end
   endfunction

   // an indicator shows when none of its mask bits is set in the icon byte
   function automatic void note_icons(logic [7:0] icons);
      event_beat_type e;
      e = plain_beat(KIND_ICONS);
      e.news_on    = ((icons & masks.no_news) == 8'h00);
      e.traffic_on = ((icons & masks.no_traffic) == 8'h00);
      e.rds_on     = ((icons & masks.no_rds) == 8'h00);
      beats_due.push_back(e);
   endfunction

   // bit 5 clear is manual, else bit 1 picks preset or update list
   function automatic void note_mode(logic [7:0] m);
      mode_type       md;
      event_beat_type e;
      if (!m[5]) md = MODE_MANUAL;
      else if (!m[1]) md = MODE_PRESET;
      else md = MODE_UPDATE;
      if (md != shown_mode) begin
         shown_mode   = md;
         e            = plain_beat(KIND_MODE);
         e.radio_mode = md;
         beats_due.push_back(e);
      end
   endfunction

   // completion: the location byte decides which events the segment makes
   function automatic void finish_segment();
      char_row_type seg;
      logic [2:0]   mx, idx;
      logic         sel, fs;
      seg = '{default: '0};
      for (int i = 0; i < SEGMENT_CHARS; i++)
         seg[i] = text_bytes[(SEG_FIRST + i) % BUFFER_BYTES][6:0];
      mx  = location[7:5];
      idx = location[4:2];
      fs  = location[1];
      sel = location[0];

      if (mx != 0 && fs && !sel) queue_text(KIND_BLINK_ADD, seg, SEGMENT_CHARS);
      else beats_due.push_back(plain_beat(KIND_BLINK_STOP));

      // menu entry, the menu stays up
      if (mx != 0 && !fs) begin
         if (!menu_shown) begin
            beats_due.push_back(plain_beat(KIND_MENU_SHOW));
            menu_shown = 1'b1;
         end
         if (sel) queue_text(KIND_MENU_ITEM, seg, SEGMENT_CHARS);
         return;
      end
      if (menu_shown) begin
         beats_due.push_back(plain_beat(KIND_MENU_HIDE));
         menu_shown = 1'b0;
      end

      if (mx == 0 && sel) begin
         queue_text(KIND_TEXT, seg, SEGMENT_CHARS);
      end else if (fs && sel) begin
         // fullscreen: index 0 restarts, index equal to the count ends the text
         if (idx == 0) long_len = 0;
         for (int i = 0; i < LONG_APPEND_CHARS; i++) begin
            if (long_len < LONG_TEXT_CHARS) begin
               long_text[long_len] = seg[i];
               long_len++;
            end
         end
         if (idx == mx) queue_text(KIND_TEXT, long_text, long_len);
      end
   endfunction

   function automatic void assemble_frame_events(frame_type f);
      bit done, stop;
      done = 1'b0;
      stop = 1'b0;
      if (f[0] == FT_ICONS) begin
         note_icons(f[2]);
         note_mode(f[4]);
      end else if (f[0] == FT_START) begin
         fill_pos      = 0;
         text_bytes[0] = '0;
         if (f[1] == ST_ICONS) begin
            note_icons(f[3]);
            note_mode(f[5]);
            location = f[7];
         end else if (f[1] == ST_TEXT) begin
            location = f[4];
            for (int i = 5; i < 8; i++) begin
               text_bytes[fill_pos] = f[i];
               fill_pos++;
            end
         end
      end else if (f[0] >= CONT_LO && f[0] <= CONT_HI && f[0] != FT_NOP) begin
         // append until a zero; the zero is stored too if there is room
         for (int i = 1; i < 8 && !stop; i++) begin
            if (fill_pos < BUFFER_BYTES) text_bytes[fill_pos] = f[i];
            if (f[i] == 8'h00) begin
               done = (i < 7);
               stop = 1'b1;
            end else if (fill_pos < BUFFER_BYTES) begin
               fill_pos++;
            end
         end
         if (done) finish_segment();
      end
   endfunction

   // ------------------------------------------------------------------------
   // event side: random stalls and the checker
   // ------------------------------------------------------------------------

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady && $urandom_range(0, 2) == 0) rsp_hold <= pick_gap();
      end
   end

   function automatic void check_event_beat(event_beat_type got);
      event_beat_type want;
      if (beats_due.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("event beat with nothing expected: kind %0d chars %h count %0d",
                     got.kind, got.chars, got.chars_valid);
         return;
      end
      want = beats_due.pop_front();
      if (got.kind !== want.kind || got.chars !== want.chars ||
          got.chars_valid !== want.chars_valid || got.last !== want.last ||
          got.news_on !== want.news_on || got.traffic_on !== want.traffic_on ||
          got.rds_on !== want.rds_on || got.radio_mode !== want.radio_mode) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("event beat mismatch (expected/actual): kind %0d/%0d chars %h/%h",
                     want.kind, got.kind, want.chars, got.chars);
            $display("   count %0d/%0d last %0b/%0b news %0b/%0b traffic %0b/%0b",
                     want.chars_valid, got.chars_valid, want.last, got.last,
                     want.news_on, got.news_on, want.traffic_on, got.traffic_on);
            $display("   rds %0b/%0b mode %0d/%0d",
                     want.rds_on, got.rds_on, want.radio_mode, got.radio_mode);
         end
      end
   endfunction

   // sampled at the rising edge, before the block updates its outputs
   always @(posedge clock) begin : rsp_monitor
      event_beat_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind        = kind_type'(rsp_kind);
         got.chars       = {rsp_char_d, rsp_char_c, rsp_char_b, rsp_char_a};
         got.chars_valid = rsp_chars_valid;
         got.last        = rsp_last;
         got.news_on     = rsp_news_on;
         got.traffic_on  = rsp_traffic_on;
         got.rds_on      = rsp_rds_on;
         got.radio_mode  = rsp_radio_mode;
         check_event_beat(got);
      end
   end

   // ------------------------------------------------------------------------
   // frame side
   // ------------------------------------------------------------------------

   // called at a falling edge; returns at a falling edge after the handshake
   task automatic send_frame(input frame_type f);
      int unsigned gap;
      req_valid <= 1'b1;
      {req_byte7, req_byte6, req_byte5, req_byte4,
       req_byte3, req_byte2, req_byte1, req_byte0} <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      assemble_frame_events(f);
      frames_sent++;
      @(negedge clock);
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // stop sending until every queued beat is out, then wait some more
   task automatic hold_off(input int unsigned extra);
      req_valid <= 1'b0;
      while (beats_due.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   // masks only change while the block is idle
   task automatic write_mask(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      hold_off(SETTLE_CYCLES);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_NO_NEWS:    masks.no_news    = value;
         CSR_NO_RDS:     masks.no_rds     = value;
         CSR_NO_TRAFFIC: masks.no_traffic = value;
         default: ;
      endcase
   endtask

   task automatic set_masks(input logic [7:0] news, rds, traffic);
      write_mask(CSR_NO_NEWS, news);
      write_mask(CSR_NO_RDS, rds);
      write_mask(CSR_NO_TRAFFIC, traffic);
   endtask

   // start frame, full continuations, then one with a zero in bytes 1..6
   task automatic send_segment(input logic [7:0] loc, input int unsigned max_full);
      frame_type   f;
      int unsigned z;
      if ($urandom_range(0, 1))
         f = frame_of(FT_START, ST_TEXT, 8'($urandom), 8'($urandom), loc,
                      text_char(), text_char(), 8'($urandom));
      else
         f = frame_of(FT_START, ST_ICONS, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), loc);
      send_frame(f);
      repeat ($urandom_range(0, max_full))
         send_frame(frame_of(cont_type(), text_char(), text_char(), text_char(),
                             text_char(), text_char(), text_char(), text_char()));
      z    = $urandom_range(1, 6);
      f[0] = cont_type();
      for (int i = 1; i < 8; i++)
         f[i] = (i < z) ? text_char() : (i == z) ? 8'h00 : 8'($urandom);
      send_frame(f);
   endtask

   // fullscreen segments from index 0 up to the segment count
   task automatic send_fullscreen_run(input int unsigned segs);
      logic [2:0] mx, idx;
      mx = 3'($urandom_range(1, 7));
      for (int s = 0; s < segs; s++) begin
         if (s == 0) idx = 3'd0;
         else if (s == segs - 1) idx = mx;
         else do idx = 3'($urandom_range(1, 7)); while (idx == mx);
         send_segment({mx, idx, 2'b11}, 1);
      end
   endtask

   // frames that are dropped or only partly useful
   task automatic send_noise();
      frame_type f;
      f = frame_of(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      case ($urandom_range(0, 3))
         1: case ($urandom_range(0, 2))
               0: f[0] = FT_NOP;
               1: f[0] = 8'($urandom_range(0, CONT_LO - 1));
               default: f[0] = 8'($urandom_range(CONT_HI + 1, 255));
            endcase
         2: begin
            // zero only in byte 7: appends without completing
            f[0] = cont_type();
            for (int i = 1; i < 7; i++) f[i] = text_char();
            f[7] = 8'h00;
         end
         3: f[0] = FT_START;
         default: ;
      endcase
      noise_frames++;
      send_frame(f);
   endtask

   task automatic icon_burst();
      repeat (3)
         send_frame(frame_of(FT_ICONS, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      send_frame(frame_of(FT_START, ST_ICONS, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom)));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset masks, all three mode decodes, an unchanged mode
   task automatic test_icon_frames();
      send_frame(frame_of(FT_ICONS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(frame_of(FT_ICONS, 8'hFF, 8'hFF, 8'hFF, 8'h20, 8'hFF, 8'hFF, 8'hFF));
      send_frame(frame_of(FT_ICONS, 8'h00, 8'h05, 8'h00, 8'h22, 8'h00, 8'h00, 8'h00));
      send_frame(frame_of(FT_ICONS, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00));
      send_frame(frame_of(FT_ICONS, 8'h00, 8'h03, 8'h00, 8'hDF, 8'h00, 8'h00, 8'h00));
   endtask

   // types just outside the continuation range, no-op, other sub-type
   task automatic test_ignored_frames();
      send_frame(frame_of(FT_NOP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(frame_of(CONT_LO - 1, 8'h00, 8'h11, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(frame_of(CONT_HI + 1, 8'h00, 8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(frame_of(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_frame(frame_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // zero in the last byte stops the append but completes nothing
      send_frame(frame_of(CONT_LO, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h00));
      send_frame(frame_of(FT_START, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC));
   endtask

   task automatic test_text_segments();
      // raw text with arrows; the buffer overruns and the zero still completes
      send_frame(frame_of(FT_START, ST_TEXT, 8'h00, 8'hFF, 8'h01, 8'd7, 8'd8, 8'd9));
      send_frame(frame_of(CONT_LO, 8'd10, 8'h41, 8'h42, 8'h80, 8'hFF, 8'h7F, 8'h01));
      send_frame(frame_of(CONT_HI, 8'h7E, 8'h20, 8'hC1, 8'h3F, 8'd8, 8'd9, 8'h55));
      repeat (3)
         send_frame(frame_of(cont_type(), text_char(), text_char(), text_char(),
                             text_char(), text_char(), text_char(), text_char()));
      send_frame(frame_of(8'h55, 8'h00, 8'h33, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00));

      // blink add from an icon-carrying start frame, zero in byte 6
      send_frame(frame_of(FT_START, ST_ICONS, 8'h00, 8'h06, 8'h00, 8'h20, 8'h00, 8'h22));
      send_frame(frame_of(8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h00, 8'h99));

      // menu item shows the menu, then a menu frame without select
      send_frame(frame_of(FT_START, ST_TEXT, 8'h00, 8'h00, 8'h21, 8'h48, 8'h49, 8'h4A));
      send_frame(frame_of(8'h40, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_frame(frame_of(FT_START, ST_TEXT, 8'h00, 8'h00, 8'h20, 8'h4B, 8'h4C, 8'h4D));
      send_frame(frame_of(8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

      // fullscreen: first segment hides the menu, the second ends the long text
      send_frame(frame_of(FT_START, ST_TEXT, 8'h00, 8'h00, 8'h23, 8'h50, 8'h51, 8'h52));
      send_frame(frame_of(8'h41, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(frame_of(FT_START, ST_ICONS, 8'h00, 8'h00, 8'h00, 8'h22, 8'h00, 8'h27));
      send_frame(frame_of(8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   // mask extremes and random masks, icon frames under each
   task automatic test_mask_settings();
      set_masks(8'hFF, 8'hFF, 8'hFF);
      icon_burst();
      set_masks(8'h00, 8'h00, 8'h00);
      icon_burst();
      repeat (2) begin
         set_masks(8'($urandom), 8'($urandom), 8'($urandom));
         icon_burst();
      end
   endtask

   // mostly well-formed segments with random content, some noise
   task automatic test_random_traffic();
      int unsigned goal, half, r;
      bit          remapped;
      goal     = frames_sent - noise_frames + RANDOM_FRAMES;
      half     = frames_sent - noise_frames + RANDOM_FRAMES / 2;
      remapped = 1'b0;
      while (frames_sent - noise_frames < goal) begin
         steady = ($urandom_range(0, 4) == 0);
         if (!remapped && frames_sent - noise_frames >= half) begin
            set_masks(8'($urandom), 8'($urandom), 8'($urandom));
            remapped = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 40) send_segment(rand_location(), 4);
         else if (r < 55) send_fullscreen_run($urandom_range(2, 4));
         else if (r < 70)
            send_frame(frame_of(FT_ICONS, 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
         else if (r < 93) send_noise();
         else hold_off(0);   // sender waits for every queued beat
      end
      steady = 1'b0;
   endtask

   // ten fullscreen segments overflow the long text
   task automatic test_long_text_full();
      send_fullscreen_run(10);
   endtask

   initial begin
      reset_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_icon_frames();
      test_ignored_frames();
      test_text_segments();
      test_mask_settings();
      test_random_traffic();
      test_long_text_full();

      // drain, then give the block time to show any stray beat
      hold_off(SETTLE_CYCLES);
      if (mismatches == 0 && beats_due.size() == 0) begin
         $display("display_frame_text_assembler_core_test passed");
      end else begin
         if (beats_due.size() != 0)
            $display("expected event beats never seen: %0d", beats_due.size());
         $display("display_frame_text_assembler_core_test failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d event beats still expected", beats_due.size());
      $display("display_frame_text_assembler_core_test failed");
      $finish;
   end

endmodule
